// File: design/tpsm_pkg.sv
package tpsm_pkg;

  localparam int TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF = 32;

  // fade ramp length in samples
  localparam int FADE_LEN = 1000;

  localparam int STEP_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int LEN_W      = 24;
  localparam int PCM_W      = 16;
  localparam int REM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SINE_W     = 15;
  localparam int ACC_W      = 35;
  localparam int MAG_W      = 33;
  localparam int MUL_A_W    = 17;
  localparam int CNT_W      = 4;
  localparam int QDEPTH     = 2;

  localparam logic [SINE_W-1:0] PCM_MAX = 15'd32767;

  // divide by FADE_LEN as a multiply by ceil(2^RECIP_SH / FADE_LEN); exact for
  // every scaled magnitude below the saturation bound, which fits in DIV_W bits
  localparam int FADE_SH  = $clog2(FADE_LEN);
  localparam int DIV_W    = SINE_W + FADE_SH;
  localparam int RECIP_SH = DIV_W + FADE_SH;
  localparam int RECIP_W  = DIV_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN));
  localparam logic [MAG_W-1:0] SAT_NUM = MAG_W'(64'(FADE_LEN) << SINE_W);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_ONE    = 3'd0,
    REG_STEP_TWO    = 3'd1,
    REG_STEP_THREE  = 3'd2,
    REG_GAIN_ONE    = 3'd3,
    REG_GAIN_TWO    = 3'd4,
    REG_GAIN_THREE  = 3'd5,
    REG_TONE_LENGTH = 3'd6
  } cfg_reg_t;

  // per-beat job descriptor handed from front to back
  typedef struct packed {
    logic             finished;
    logic             last;
    logic             fade;
    logic [REM_W-1:0] rem;
  } ctl_t;

  // quarter-wave entry k: Taylor sine to degree 9 in Q2.30, scaled to Q15
  function automatic logic [SINE_W-1:0] quarter_entry(input int unsigned k,
                                                      input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    x  = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tbits - 3))) >> (tbits - 2);
    x2 = (x * x) >> 30;
    p  = ONE_Q30 - x2 / 64'd72;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd42;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd20;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd6;
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

// File: design/tpsm_front.sv
module tpsm_front #(
  parameter int PHASE_BITS = tpsm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = tpsm_pkg::TABLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_restart,
  output logic                                  in_stall,
  input  logic [2:0][tpsm_pkg::STEP_W-1:0]      steps,
  input  logic [tpsm_pkg::LEN_W-1:0]            tone_length,
  input  logic                                  q_full,
  output logic                                  q_push,
  output tpsm_pkg::ctl_t                        q_ctl,
  output logic [2:0][TABLE_BITS-1:0]            q_idx
);
  import tpsm_pkg::*;

  logic [LEN_W-1:0]                 sidx_r, sidx_nxt, cur_idx, remaining;
  logic [2:0][PHASE_BITS-1:0]       ph_r, ph_nxt, cur_ph;
  logic                             fin;
  logic                             accept;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept;

  always_comb begin
    cur_idx   = in_restart ? '0 : sidx_r;
    cur_ph    = in_restart ? '0 : ph_r;
    remaining = tone_length - cur_idx;
    fin       = cur_idx >= tone_length;

    q_ctl.finished = fin;
    q_ctl.last     = ~fin & (remaining == LEN_W'(1));
    q_ctl.fade     = remaining < LEN_W'(FADE_LEN);
    q_ctl.rem      = remaining[REM_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q_idx[i] = cur_ph[i][PHASE_BITS-1 -: TABLE_BITS];
    end

    sidx_nxt = sidx_r;
    ph_nxt   = ph_r;
    if (accept) begin
      sidx_nxt = cur_idx;
      ph_nxt   = cur_ph;
      // silence holds the position where the tone ended
      if (!fin) begin
        sidx_nxt = cur_idx + LEN_W'(1);
        for (int i = 0; i < 3; i++) begin
          ph_nxt[i] = cur_ph[i] + steps[i][PHASE_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r <= '0;
      ph_r   <= '0;
    end else begin
      sidx_r <= sidx_nxt;
      ph_r   <= ph_nxt;
    end
  end

`ifndef SYNTHESIS
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !fin |=> sidx_r == $past(cur_idx) + LEN_W'(1))
    else $error("sample index did not advance after a tone beat");

  a_silence_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fin |=> ph_r == $past(cur_ph) && sidx_r == $past(cur_idx))
    else $error("phase moved during silence");
`endif

endmodule

// File: design/tpsm_queue.sv
module tpsm_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import tpsm_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  logic [W-1:0]           mem [QDEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]         cnt_r, cnt_nxt;

  assign full  = cnt_r == (PTR_W + 1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");
`endif

endmodule

// File: design/tpsm_back.sv
module tpsm_back #(
  parameter int TABLE_BITS = tpsm_pkg::TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  tpsm_pkg::ctl_t                       q_ctl,
  input  logic [2:0][TABLE_BITS-1:0]           q_idx,
  input  logic [2:0][tpsm_pkg::GAIN_W-1:0]     gains,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tpsm_pkg::PCM_W-1:0]    out_pcm,
  output logic                                 out_last,
  output logic                                 out_finished
);
  import tpsm_pkg::*;

  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int ADDR_W  = TABLE_BITS - 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MAC  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_FADE = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } st_t;

  logic [SINE_W-1:0] sine_tab [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    assign sine_tab[k] = quarter_entry(k, TABLE_BITS);
  end

  st_t                       state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  ctl_t                      ctl_r, ctl_nxt;
  logic [2:0][TABLE_BITS-1:0] idx_r, idx_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      sgn_r, sgn_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic [MAG_W-1:0]          plo_r, plo_nxt;
  logic [MAG_W-1:0]          num_r, num_nxt;
  logic [PCM_W-1:0]          res_pcm_r, res_pcm_nxt;
  logic                      res_last_r, res_last_nxt;
  logic                      res_fin_r, res_fin_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [PCM_W-1:0]          out_pcm_r, out_pcm_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_fin_r, out_fin_nxt;

  logic [TABLE_BITS-1:0]     cur;
  logic [ADDR_W-1:0]         addr;
  logic [SINE_W-1:0]         sine;
  logic                      neg;
  logic [MUL_A_W-1:0]        mul_a;
  logic [GAIN_W-1:0]         mul_b;
  logic [MAG_W-1:0]          mul_p;
  logic [ACC_W-1:0]          abs_v;
  logic [MAG_W-MUL_A_W:0]    q_hi;
  logic [SINE_W-1:0]         m15;
  logic [MAG_W+16:0]         prod_full;
  logic [DIV_W+RECIP_W-1:0]  recip_p;

  always_comb begin
    cur   = idx_r[cnt_r[1:0]];
    neg   = cur[TABLE_BITS-1];
    addr  = cur[TABLE_BITS-2] ? ADDR_W'(QUARTER) - {1'b0, cur[TABLE_BITS-3:0]}
                              : {1'b0, cur[TABLE_BITS-3:0]};
    sine  = sine_tab[addr];

    // one shared multiplier: partial gains, then the fade's two partial products
    mul_a = {2'b00, sine};
    mul_b = gains[cnt_r[1:0]];
    if (state_r == ST_FADE) begin
      mul_b = ctl_r.rem;
      mul_a = cnt_r[0] ? {1'b0, mag_r[MAG_W-1:MUL_A_W]} : mag_r[MUL_A_W-1:0];
    end
    mul_p = mul_a * mul_b;

    abs_v     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    q_hi      = abs_v[MAG_W-1:16];
    prod_full = {mul_p, 17'd0} + {17'd0, plo_r};
    recip_p   = num_r[DIV_W-1:0] * RECIP;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctl_nxt       = ctl_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    sgn_nxt       = sgn_r;
    mag_nxt       = mag_r;
    plo_nxt       = plo_r;
    num_nxt       = num_r;
    res_pcm_nxt   = res_pcm_r;
    res_last_nxt  = res_last_r;
    res_fin_nxt   = res_fin_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_pcm_nxt   = out_pcm_r;
    out_last_nxt  = out_last_r;
    out_fin_nxt   = out_fin_r;
    q_pop         = 1'b0;
    m15           = '0;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          ctl_nxt      = q_ctl;
          idx_nxt      = q_idx;
          res_fin_nxt  = q_ctl.finished;
          res_last_nxt = q_ctl.last;
          acc_nxt      = '0;
          cnt_nxt      = '0;
          if (q_ctl.finished) begin
            res_pcm_nxt = '0;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        acc_nxt = neg ? acc_r - $signed({2'b00, mul_p})
                      : acc_r + $signed({2'b00, mul_p});
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = ST_ABS;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ABS: begin
        sgn_nxt = acc_r[ACC_W-1];
        mag_nxt = abs_v[MAG_W-1:0];
        cnt_nxt = '0;
        if (ctl_r.fade) begin
          state_nxt = ST_FADE;
        end else begin
          m15         = (|q_hi[MAG_W-MUL_A_W:SINE_W]) ? PCM_MAX : q_hi[SINE_W-1:0];
          res_pcm_nxt = acc_r[ACC_W-1] ? -{1'b0, m15} : {1'b0, m15};
          state_nxt   = ST_OUT;
        end
      end
      ST_FADE: begin
        if (!cnt_r[0]) begin
          plo_nxt = mul_p;
          cnt_nxt = CNT_W'(1);
        end else begin
          // magnitude * remaining / 65536, left for the divide by FADE_LEN
          num_nxt   = prod_full[MAG_W+15:16];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // at or above the bound the quotient would pass full scale
        m15         = (num_r >= SAT_NUM) ? PCM_MAX : recip_p[RECIP_SH +: SINE_W];
        res_pcm_nxt = sgn_r ? -{1'b0, m15} : {1'b0, m15};
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pcm_nxt   = res_pcm_r;
          out_last_nxt  = res_last_r & ~res_fin_r;
          out_fin_nxt   = res_fin_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r      <= ctl_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    sgn_r      <= sgn_nxt;
    mag_r      <= mag_nxt;
    plo_r      <= plo_nxt;
    num_r      <= num_nxt;
    res_pcm_r  <= res_pcm_nxt;
    res_last_r <= res_last_nxt;
    res_fin_r  <= res_fin_nxt;
    out_pcm_r  <= out_pcm_nxt;
    out_last_r <= out_last_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pcm      = $signed(out_pcm_r);
  assign out_last     = out_last_r;
  assign out_finished = out_fin_r;

`ifndef SYNTHESIS
  a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> out_pcm_r == '0 && !out_last_r)
    else $error("silent beat carries a sample or a last mark");

  a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pcm_r != 16'h8000)
    else $error("sample outside the saturation range");
`endif

endmodule

// File: design/three_partial_sine_mixer.sv
// Three-partial additive sine source. Every tick beat on the input channel
// yields one 16-bit PCM beat; restart clears the three phase accumulators and
// the sample index first. The last beat of the tone carries last, and ticks
// after the end give silence with finished set. A front stage keeps the
// phases and sample index and hands a job descriptor to a two-entry queue, so
// ticks are taken while the back end works. The back end shares one 17x16
// multiplier and works through each beat in turn (pop, three partial products,
// magnitude, output register); over the last FADE_LEN - 1 beats it adds two
// partial products for the fade and a reciprocal multiply for the divide by
// FADE_LEN. Silent beats go from the pop straight to the output register. A
// stalled output beat holds the back end until it is taken. The user must write
// registers through cfg_we/cfg_index/cfg_wdata only while no beat is in flight;
// the block does not enforce this. Writes to an unused index are dropped.
module three_partial_sine_mixer #(
  parameter int PHASE_BITS = tpsm_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = tpsm_pkg::TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tpsm_pkg::PCM_W-1:0]   out_pcm,
  output logic                                out_last,
  output logic                                out_finished,
  input  logic                                cfg_we,
  input  logic [tpsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tpsm_pkg::*;

  localparam int QW = $bits(ctl_t) + 3 * TABLE_BITS;

  logic [2:0][STEP_W-1:0]      steps_r;
  logic [2:0][GAIN_W-1:0]      gains_r;
  logic [LEN_W-1:0]            len_r;

  logic                        q_push, q_pop, q_full, q_empty;
  ctl_t                        f_ctl, b_ctl;
  logic [2:0][TABLE_BITS-1:0]  f_idx, b_idx;
  logic [QW-1:0]               q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r[0] <= 32'd142191661;
      steps_r[1] <= 32'd212313576;
      steps_r[2] <= 32'd475270757;
      gains_r[0] <= 16'd28087;
      gains_r[1] <= 16'd23406;
      gains_r[2] <= 16'd14043;
      len_r      <= 24'd22050;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP_ONE:    steps_r[0] <= cfg_wdata[STEP_W-1:0];
        REG_STEP_TWO:    steps_r[1] <= cfg_wdata[STEP_W-1:0];
        REG_STEP_THREE:  steps_r[2] <= cfg_wdata[STEP_W-1:0];
        REG_GAIN_ONE:    gains_r[0] <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_TWO:    gains_r[1] <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_THREE:  gains_r[2] <= cfg_wdata[GAIN_W-1:0];
        REG_TONE_LENGTH: len_r      <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tpsm_front #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_restart  (in_restart),
    .in_stall    (in_stall),
    .steps       (steps_r),
    .tone_length (len_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_ctl       (f_ctl),
    .q_idx       (f_idx)
  );

  tpsm_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({f_ctl, f_idx}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_ctl, b_idx} = q_dout;

  tpsm_back #(
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_ctl        (b_ctl),
    .q_idx        (b_idx),
    .gains        (gains_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pcm      (out_pcm),
    .out_last     (out_last),
    .out_finished (out_finished)
  );

endmodule

// File: sim/tb_three_partial_sine_mixer.sv
`timescale 1ns / 1ps

module tb_three_partial_sine_mixer;
  import tpsm_pkg::*;

  localparam int TB_TABLE_BITS = 10;
  localparam int TB_PHASE_BITS = 32;
  localparam int TB_QUARTER    = 1 << (TB_TABLE_BITS - 2);

  typedef struct {
    logic signed [PCM_W-1:0] pcm;
    logic                    last;
    logic                    finished;
  } sample_t;

  class sine_mix_board;
    bit [STEP_W-1:0] step[3];
    bit [GAIN_W-1:0] gain[3];
    bit [LEN_W-1:0]  tone_len;
    bit [TB_PHASE_BITS-1:0] phase[3];
    bit [LEN_W-1:0]  idx;
    bit [SINE_W-1:0] quarter[0:TB_QUARTER];
    sample_t samples_due[$];
    int errors, ticks, faded, clipped, ends, silent;

    function new();
      longint unsigned x, x2, p, s, v;
      for (longint unsigned k = 0; k <= TB_QUARTER; k++) begin
        // quarter-wave point from a degree-9 Taylor series in Q2.30
        x  = (64'd1686629713 * k + TB_QUARTER / 2) / TB_QUARTER;
        x2 = (x * x) >> 30;
        p  = (64'd1 << 30) - x2 / 72;
        p  = (64'd1 << 30) - ((x2 * p) >> 30) / 42;
        p  = (64'd1 << 30) - ((x2 * p) >> 30) / 20;
        p  = (64'd1 << 30) - ((x2 * p) >> 30) / 6;
        s  = (x * p) >> 30;
        v  = (s * 32767 + (64'd1 << 29)) >> 30;
        if (v > 32767) begin
          v = 32767;
        end
        quarter[k] = v[SINE_W-1:0];
      end
      step     = '{32'd142191661, 32'd212313576, 32'd475270757};
      gain     = '{16'd28087, 16'd23406, 16'd14043};
      tone_len = 24'd22050;
      phase    = '{0, 0, 0};
      idx      = '0;
    endfunction

    function int sine_at(bit [TB_PHASE_BITS-1:0] ph);
      bit [TB_TABLE_BITS-1:0] i;
      int v;
      i = ph[TB_PHASE_BITS-1 -: TB_TABLE_BITS];
      v = i[TB_TABLE_BITS-2] ? quarter[TB_QUARTER - i[TB_TABLE_BITS-3:0]]
                             : quarter[i[TB_TABLE_BITS-3:0]];
      return i[TB_TABLE_BITS-1] ? -v : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_STEP_ONE:    step[0] = data;
        REG_STEP_TWO:    step[1] = data;
        REG_STEP_THREE:  step[2] = data;
        REG_GAIN_ONE:    gain[0] = data[GAIN_W-1:0];
        REG_GAIN_TWO:    gain[1] = data[GAIN_W-1:0];
        REG_GAIN_THREE:  gain[2] = data[GAIN_W-1:0];
        REG_TONE_LENGTH: tone_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit restart);
      sample_t e;
      longint acc, scaled;
      bit [31:0] rem;
      ticks++;
      if (restart) begin
        phase = '{0, 0, 0};
        idx   = '0;
      end
      if (idx >= tone_len) begin
        e.pcm = '0;
        e.last = 1'b0;
        e.finished = 1'b1;
        silent++;
      end else begin
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          acc += longint'(gain[i]) * longint'(sine_at(phase[i]));
        end
        rem = 32'(tone_len) - 32'(idx);
        if (rem < FADE_LEN) begin
          scaled = acc * longint'(rem) / (longint'(FADE_LEN) * 65536);
          faded++;
        end else begin
          scaled = acc / 65536;
        end
        if (scaled > 32767) begin
          scaled = 32767;
          clipped++;
        end else if (scaled < -32767) begin
          scaled = -32767;
          clipped++;
        end
        e.pcm = scaled[PCM_W-1:0];
        e.last = (rem == 1);
        e.finished = 1'b0;
        if (e.last) begin
          ends++;
        end
        idx++;
        for (int i = 0; i < 3; i++) begin
          phase[i] += step[i];
        end
      end
      samples_due = {samples_due, e};
    endfunction

    function void check_beat(logic signed [PCM_W-1:0] pcm, logic last, logic finished);
      sample_t e;
      if (samples_due.size() == 0) begin
        errors++;
        $display("%0t: beat with no sample due: pcm %0d last %0b finished %0b",
                 $time, pcm, last, finished);
        return;
      end
      e = samples_due.pop_front();
      if (pcm !== e.pcm) begin
        errors++;
        $display("%0t: pcm expected %0d, got %0d", $time, e.pcm, pcm);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last expected %0b, got %0b", $time, e.last, last);
      end
      if (finished !== e.finished) begin
        errors++;
        $display("%0t: finished expected %0b, got %0b", $time, e.finished, finished);
      end
    endfunction
  endclass

  localparam int RUN_LIMIT = 1_000_000;
  localparam int PHASE_BEATS = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_restart = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_ONE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  logic signed [PCM_W-1:0] out_pcm;
  logic out_last;
  logic out_finished;

  sine_mix_board board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int settings = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  three_partial_sine_mixer DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pcm(out_pcm),
    .out_last(out_last),
    .out_finished(out_finished),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      board.check_beat(out_pcm, out_last, out_finished);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // leaves valid high so back-to-back beats need no second assignment
  task automatic push_tick(input bit restart);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_restart <= 1'($urandom_range(1));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    board.note_tick(restart);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.samples_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_reg(index, data);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_step();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // upper bits carry noise, the block must ignore them
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(9))
      0: d[GAIN_W-1:0] = '0;
      1: d[GAIN_W-1:0] = '1;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    logic [CFG_DATA_W-1:0] d;
    int r;
    d = $urandom;
    r = $urandom_range(99);
    if (r < 2) d[LEN_W-1:0] = '0;
    else if (r < 6) d[LEN_W-1:0] = LEN_W'(1);
    else if (r < 9) d[LEN_W-1:0] = '1;
    else if (r < 55) d[LEN_W-1:0] = LEN_W'($urandom_range(2, 300));
    else if (r < 85) d[LEN_W-1:0] = LEN_W'($urandom_range(300, 2500));
    else d[LEN_W-1:0] = LEN_W'($urandom_range(2500, 24'hFFFFFF));
    return d;
  endfunction

  initial begin
    int sent;
    int n;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // power-on settings
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);

    // quarter-turn steps at full gain: zero, clip high, zero, clip low
    settle();
    write_reg(REG_STEP_ONE, 32'h4000_0000);
    write_reg(REG_STEP_TWO, 32'h4000_0000);
    write_reg(REG_STEP_THREE, 32'h4000_0000);
    write_reg(REG_GAIN_ONE, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_TWO, 32'hFFFF_FFFF);
    write_reg(REG_GAIN_THREE, 32'hFFFF_FFFF);
    write_reg(REG_TONE_LENGTH, 32'h00FF_FFFF);
    cfg_we <= 1'b0;
    push_tick(1'b1);
    repeat (4) push_tick(1'b0);

    // short tone entirely inside the fade, then silence
    settle();
    write_reg(REG_TONE_LENGTH, 32'hAB00_0003);
    cfg_we <= 1'b0;
    push_tick(1'b1);
    repeat (4) push_tick(1'b0);

    // zero length: finished from the first tick
    settle();
    write_reg(REG_GAIN_ONE, 32'h0);
    write_reg(REG_GAIN_TWO, 32'h0);
    write_reg(REG_GAIN_THREE, 32'h0);
    write_reg(REG_TONE_LENGTH, 32'h0);
    cfg_we <= 1'b0;
    push_tick(1'b1);
    push_tick(1'b0);

    // odd steps; write to the spare index must not land anywhere
    settle();
    write_reg(REG_STEP_ONE, 32'hFFFF_FFFF);
    write_reg(REG_STEP_TWO, 32'h0);
    write_reg(REG_STEP_THREE, 32'h1234_5678);
    write_reg(REG_GAIN_ONE, 32'h0000_FFFF);
    write_reg(REG_GAIN_TWO, 32'h0001_8001);
    write_reg(REG_GAIN_THREE, 32'h0000_7FFE);
    write_reg(REG_TONE_LENGTH, 32'd1200);
    write_reg(REG_SPARE, 32'd5);
    cfg_we <= 1'b0;
    push_tick(1'b1);
    repeat (3) push_tick(1'b0);

    // length dropped below the sample index mid-tone
    settle();
    write_reg(REG_TONE_LENGTH, 32'd2);
    cfg_we <= 1'b0;
    push_tick(1'b0);
    settle();
    write_reg(REG_TONE_LENGTH, 32'd5);
    cfg_we <= 1'b0;
    push_tick(1'b0);
    push_tick(1'b0);

    // fade threshold crossing
    settle();
    write_reg(REG_TONE_LENGTH, CFG_DATA_W'(FADE_LEN + 1));
    cfg_we <= 1'b0;
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 65 : 0;
      recv_stall_pct = (ph == 0) ? 65 : (ph == 1) ? 17 : 0;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        settle();
        for (int r = int'(REG_STEP_ONE); r <= int'(REG_TONE_LENGTH); r++) begin
          if ($urandom_range(2) != 0) begin
            if (r <= int'(REG_STEP_THREE)) write_reg(CFG_IDX_W'(r), pick_step());
            else if (r <= int'(REG_GAIN_THREE)) write_reg(CFG_IDX_W'(r), pick_gain());
            else write_reg(CFG_IDX_W'(r), pick_length());
          end
        end
        if ($urandom_range(9) == 0) begin
          write_reg(REG_SPARE, $urandom);
        end
        cfg_we <= 1'b0;
        settings++;
        n = $urandom_range(10, 120);
        for (int i = 0; i < n; i++) begin
          push_tick(i == 0 ? ($urandom_range(4) != 0) : ($urandom_range(49) == 0));
          sent++;
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (board.samples_due.size() != 0) begin
      $display("%0d samples never arrived", board.samples_due.size());
    end
    $display("%0d ticks over %0d random register settings, three idle patterns",
             board.ticks, settings);
    $display("%0d faded, %0d clipped, %0d tone ends, %0d silent beats",
             board.faded, board.clipped, board.ends, board.silent);
    if (board.errors == 0 && board.samples_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: three_partial_sine_mixer.f
design/tpsm_pkg.sv
design/tpsm_front.sv
design/tpsm_queue.sv
design/tpsm_back.sv
design/three_partial_sine_mixer.sv
sim/tb_three_partial_sine_mixer.sv
